>>> design/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared types, S-box tables and round transformation functions.
// ----------------------------------------------------------------------------
package aes_pkg;

   typedef logic [127:0] state_type;

   typedef struct packed {
      logic func;
      logic last;
   } round_ctrl_type;

   localparam logic FUNC_ENCRYPT = 1'b0;
   localparam logic FUNC_DECRYPT = 1'b1;

   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [7:0] RCON_FIRST = 8'h01;

   localparam logic [2047:0] FWD_SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_TABLE = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] fwd_sbox(input logic [7:0] b);
      return FWD_SBOX_TABLE[11'd2047 - {b, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] b);
      return INV_SBOX_TABLE[11'd2047 - {b, 3'b000} -: 8];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ GF_POLY) : {v[6:0], 1'b0};
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]), fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
   endfunction

   function automatic state_type sub_bytes(input state_type s, input logic inverse);
      state_type o;
      for (int i = 0; i < 16; i++) begin
         o[127-8*i -: 8] = inverse ? inv_sbox(s[127-8*i -: 8]) : fwd_sbox(s[127-8*i -: 8]);
      end
      return o;
   endfunction

   function automatic state_type shift_rows(input state_type s, input logic inverse);
      state_type o;
      logic [1:0] src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inverse ? 2'(c - r) : 2'(c + r);
            o[127-8*(4*c+r) -: 8] = s[127-8*(4*int'(src)+r) -: 8];
         end
      end
      return o;
   endfunction

   function automatic state_type mix_columns(input state_type s, input logic inverse);
      state_type o;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      for (int c = 0; c < 4; c++) begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = s[127-8*(4*c+k) -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
         end
         for (int r = 0; r < 4; r++) begin
            if (inverse) begin
               o[127-8*(4*c+r) -: 8] = (x8[r] ^ x4[r] ^ x2[r])
                  ^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
                  ^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
                  ^ (x8[(r+3)%4] ^ a[(r+3)%4]);
            end else begin
               o[127-8*(4*c+r) -: 8] = x2[r] ^ (x2[(r+1)%4] ^ a[(r+1)%4])
                  ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
         end
      end
      return o;
   endfunction

endpackage

>>> design/aes128_block_cipher_unit.sv
// Pipeline: an input register adds the first round key, then the round stages.
// Throughput: one transaction per cycle while req_stall is low; one round per pipeline stage.
// Key expansion: runs after reset and after each key write, computing
// one round key per cycle; req_stall and csr_ready hold off during it.
// Reset: synchronous, clears pipeline valids and keys, then expands zero key.
// ----------------------------------------------------------------------------
// AES-128 block cipher unit
// Round-per-stage encrypt/decrypt pipeline with registered round key store.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit #(
   parameter int ROUND_COUNT = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   localparam int CNT_W = $clog2(ROUND_COUNT + 1);

   logic [63:0]        key_high_ff, key_high_in;
   logic [63:0]        key_low_ff, key_low_in;
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         rcon_ff, rcon_in;
   aes_pkg::state_type w_ff, w_in;
   aes_pkg::state_type rk_ff [ROUND_COUNT+1];
   aes_pkg::state_type next_w;
   logic [31:0]        t_word;

   logic               v_ff [ROUND_COUNT+1];
   logic               fn_ff [ROUND_COUNT+1];
   aes_pkg::state_type st_ff [ROUND_COUNT+1];
   logic               en [ROUND_COUNT+1];
   logic               csr_wr;

   assign csr_ready = !busy_ff;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      t_word = aes_pkg::sub_word({w_ff[23:0], w_ff[31:24]}) ^ {rcon_ff, 24'h0};
      next_w[127:96] = w_ff[127:96] ^ t_word;
      next_w[95:64]  = w_ff[95:64] ^ next_w[127:96];
      next_w[63:32]  = w_ff[63:32] ^ next_w[95:64];
      next_w[31:0]   = w_ff[31:0] ^ next_w[63:32];
   end

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      busy_in     = busy_ff;
      cnt_in      = cnt_ff;
      rcon_in     = rcon_ff;
      w_in        = w_ff;
      if (csr_wr) begin
         case (csr_index)
            aes_pkg::CSR_KEY_HIGH: begin
               key_high_in = csr_data;
               busy_in     = 1'b1;
               cnt_in      = '0;
            end
            aes_pkg::CSR_KEY_LOW: begin
               key_low_in = csr_data;
               busy_in    = 1'b1;
               cnt_in     = '0;
            end
            default: begin
            end
         endcase
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            w_in    = {key_high_ff, key_low_ff};
            rcon_in = aes_pkg::RCON_FIRST;
         end else begin
            w_in    = next_w;
            rcon_in = aes_pkg::xtime(rcon_ff);
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROUND_COUNT)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         busy_ff     <= 1'b1;
         cnt_ff      <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
      end
      rcon_ff <= rcon_in;
      w_ff    <= w_in;
      if (busy_ff && !csr_wr) begin
         rk_ff[cnt_ff] <= (cnt_ff == '0) ? {key_high_ff, key_low_ff} : next_w;
      end
   end

   assign en[ROUND_COUNT] = !v_ff[ROUND_COUNT] || !rsp_stall;
   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_en
      assign en[i] = !v_ff[i] || en[i+1];
   end

   assign req_stall = busy_ff || !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en[0]) begin
         v_ff[0] <= req_valid && !busy_ff;
      end
      if (en[0]) begin
         fn_ff[0] <= req_func;
         st_ff[0] <= {req_block_high, req_block_low}
                     ^ ((req_func == aes_pkg::FUNC_DECRYPT) ? rk_ff[ROUND_COUNT] : rk_ff[0]);
      end
   end

   for (genvar i = 1; i <= ROUND_COUNT; i++) begin : g_stage
      aes_pkg::round_ctrl_type ctrl;
      aes_pkg::state_type      rnd_out;

      assign ctrl.func = fn_ff[i-1];
      assign ctrl.last = (i == ROUND_COUNT);

      aes_round u_round (
         .ctrl      (ctrl),
         .state_in  (st_ff[i-1]),
         .key_enc   (rk_ff[i]),
         .key_dec   (rk_ff[ROUND_COUNT-i]),
         .state_out (rnd_out)
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en[i]) begin
            v_ff[i] <= v_ff[i-1];
         end
         if (en[i]) begin
            fn_ff[i] <= fn_ff[i-1];
            st_ff[i] <= rnd_out;
         end
      end
   end

   assign rsp_valid       = v_ff[ROUND_COUNT];
   assign rsp_result_high = st_ff[ROUND_COUNT][127:64];
   assign rsp_result_low  = st_ff[ROUND_COUNT][63:0];

endmodule

>>> design/aes_round.sv
// ----------------------------------------------------------------------------
// AES round
// One encryption round or one inverse round, selected per transaction.
// ----------------------------------------------------------------------------
module aes_round (
   input  aes_pkg::round_ctrl_type ctrl,
   input  aes_pkg::state_type      state_in,
   input  aes_pkg::state_type      key_enc,
   input  aes_pkg::state_type      key_dec,
   output aes_pkg::state_type      state_out
);

   aes_pkg::state_type enc_t;
   aes_pkg::state_type dec_t;

   always_comb begin
      enc_t = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_in, 1'b0), 1'b0);
      if (!ctrl.last) begin
         enc_t = aes_pkg::mix_columns(enc_t, 1'b0);
      end
      enc_t = enc_t ^ key_enc;

      dec_t = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_in, 1'b1), 1'b1) ^ key_dec;
      if (!ctrl.last) begin
         dec_t = aes_pkg::mix_columns(dec_t, 1'b1);
      end

      state_out = (ctrl.func == aes_pkg::FUNC_DECRYPT) ? dec_t : enc_t;
   end

endmodule

>>> design/aes128_block_cipher_unit_checker.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher unit checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module aes128_block_cipher_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_result_high,
   input logic [63:0] rsp_result_low,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [1:0]  csr_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_high)
                                 && $stable(rsp_result_low))
      else $error("stalled transaction changed");

   a_reset_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall && !csr_ready)
      else $error("request taken before key expansion after reset");

   a_key_write_busy: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready
      && (csr_index == aes_pkg::CSR_KEY_HIGH || csr_index == aes_pkg::CSR_KEY_LOW)
      |=> req_stall && !csr_ready)
      else $error("request taken during key expansion");

   a_expand_blocks_req: assert property (@(posedge clock)
      !csr_ready |-> req_stall)
      else $error("request open while csr port busy");

endmodule

bind aes128_block_cipher_unit aes128_block_cipher_unit_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_result_high (rsp_result_high),
   .rsp_result_low  (rsp_result_low),
   .csr_valid       (csr_valid),
   .csr_ready       (csr_ready),
   .csr_index       (csr_index)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block cipher unit testbench
// Drives encrypt/decrypt transactions under several key settings and idle
// patterns; every response is compared with an in-bench cipher model.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic        func;
      logic [63:0] blk_hi;
      logic [63:0] blk_lo;
      logic        chk;
      logic [63:0] exp_hi;
      logic [63:0] exp_lo;
   } vec_type;

   localparam logic [1:0] CSR_SPARE_A = 2'd2;
   localparam logic [1:0] CSR_SPARE_B = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result_high;
   logic [63:0] rsp_result_low;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [7:0]   sbox_f [256];
   logic [7:0]   sbox_i [256];
   logic [127:0] key_reg;
   logic [127:0] rkeys [11];
   logic [127:0] pending_blocks [$];
   int           mismatches = 0;
   int           phase = 0;
   int           send_idle = 0;
   int           recv_idle = 0;

   aes128_block_cipher_unit uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #50ms;
      $display("[aes128_block_cipher_unit] ERROR");
      $finish;
   end

   function automatic logic [7:0] gdbl(logic [7:0] v);
      return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
   endfunction

   function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gdbl(a);
      end
      return acc;
   endfunction

   function automatic logic [7:0] byte_of(logic [127:0] s, int i);
      return s[127-8*i -: 8];
   endfunction

   task automatic expand_keys();
      logic [7:0] w [176];
      logic [7:0] t [4];
      logic [7:0] tmp, rc;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) w[i] = byte_of(key_reg, i);
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) t[j] = w[(i-1)*4+j];
         if ((i & 3) == 0) begin
            tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
            for (int j = 0; j < 4; j++) t[j] = sbox_f[t[j]];
            t[0] ^= rc;
            rc = gdbl(rc);
         end
         for (int j = 0; j < 4; j++) w[i*4+j] = w[(i-4)*4+j] ^ t[j];
      end
      for (int r = 0; r < 11; r++)
         for (int i = 0; i < 16; i++) rkeys[r][127-8*i -: 8] = w[16*r+i];
   endtask

   function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] o [16];
      logic [7:0] fm [4];
      logic [7:0] im [4];
      logic [7:0] acc;
      logic [127:0] res;
      int rr;
      fm = '{8'd2, 8'd3, 8'd1, 8'd1};
      im = '{8'd14, 8'd11, 8'd13, 8'd9};
      for (int i = 0; i < 16; i++) s[i] = byte_of(blk, i) ^ byte_of(rkeys[dec ? 10 : 0], i);
      for (int step = 1; step <= 10; step++) begin
         rr = dec ? 10 - step : step;
         if (!dec) for (int i = 0; i < 16; i++) s[i] = sbox_f[s[i]];
         o = s;
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               s[4*c+r] = o[4*(dec ? ((c-r+4)&3) : ((c+r)&3)) + r];
         if (dec) for (int i = 0; i < 16; i++) s[i] = sbox_i[s[i]];
         if (dec) for (int i = 0; i < 16; i++) s[i] ^= byte_of(rkeys[rr], i);
         if ((!dec && step < 10) || (dec && rr > 0)) begin
            o = s;
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  acc = '0;
                  for (int k = 0; k < 4; k++)
                     acc ^= gmul(o[4*c+k], dec ? im[(k-r+4)&3] : fm[(k-r+4)&3]);
                  s[4*c+r] = acc;
               end
         end
         if (!dec) for (int i = 0; i < 16; i++) s[i] ^= byte_of(rkeys[rr], i);
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic pick_idle();
      case (phase)
         1: begin send_idle = 47; recv_idle = 0; end
         2: begin send_idle = 0; recv_idle = 47; end
         3: begin send_idle = 15; recv_idle = 15; end
         default: begin send_idle = 0; recv_idle = 0; end
      endcase
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
      if (idx == aes_pkg::CSR_KEY_HIGH) key_reg[127:64] = val;
      else if (idx == aes_pkg::CSR_KEY_LOW) key_reg[63:0] = val;
      else return;
      expand_keys();
   endtask

   task automatic send_item(logic f, logic [63:0] hi, logic [63:0] lo);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_block_high <= hi;
      req_block_low  <= lo;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_blocks.push_back(cipher_block(f, {hi, lo}));
      @(negedge clock);
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < recv_idle);

   always @(posedge clock) begin
      logic [127:0] exp_blk;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", {rsp_result_high, rsp_result_low});
         end else begin
            exp_blk = pending_blocks.pop_front();
            if (exp_blk != {rsp_result_high, rsp_result_low}) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h actual %h", exp_blk,
                           {rsp_result_high, rsp_result_low});
            end
         end
      end
   end

   vec_type directed [] = '{
      '{aes_pkg::FUNC_ENCRYPT, 64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0, 64'h0, 64'h0},
      '{aes_pkg::FUNC_ENCRYPT, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{aes_pkg::FUNC_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0},
      '{aes_pkg::FUNC_ENCRYPT, '1, '1, 1'b0, 64'h0, 64'h0},
      '{aes_pkg::FUNC_DECRYPT, '1, '1, 1'b0, 64'h0, 64'h0},
      '{aes_pkg::FUNC_DECRYPT, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
      '{aes_pkg::FUNC_ENCRYPT, 64'h8000000000000000, 64'h1, 1'b0, 64'h0, 64'h0},
      '{aes_pkg::FUNC_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0}
   };

   initial begin
      logic [127:0] got;
      logic [127:0] keys [6];
      for (int i = 0; i < 256; i++) begin
         sbox_f[i] = aes_pkg::FWD_SBOX_TABLE[2047-8*i -: 8];
         sbox_i[i] = aes_pkg::INV_SBOX_TABLE[2047-8*i -: 8];
      end
      key_reg = '0;
      expand_keys();
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         if (directed[i].chk) begin
            got = cipher_block(directed[i].func, {directed[i].blk_hi, directed[i].blk_lo});
            if (got != {directed[i].exp_hi, directed[i].exp_lo}) begin
               mismatches++;
               if (mismatches <= 10) $display("table row %0d: model %h", i, got);
            end
         end
         send_item(directed[i].func, directed[i].blk_hi, directed[i].blk_lo);
      end
      wait_drain();
      keys[0] = 128'h2b7e151628aed2a6abf7158809cf4f3c;
      keys[1] = '1;
      keys[2] = {64'h8000000000000000, 64'h0};
      keys[3] = {$urandom, $urandom, $urandom, $urandom};
      keys[4] = {$urandom, $urandom, $urandom, $urandom};
      keys[5] = '0;
      write_csr(aes_pkg::CSR_KEY_HIGH, keys[0][127:64]);
      write_csr(aes_pkg::CSR_KEY_LOW, keys[0][63:0]);
      send_item(aes_pkg::FUNC_ENCRYPT, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
      wait_drain();
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, 64'h5a5a);
      send_item(aes_pkg::FUNC_DECRYPT, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
      wait_drain();
      for (int p = 0; p < 6; p++) begin
         write_csr(aes_pkg::CSR_KEY_HIGH, keys[p][127:64]);
         if (p != 4) write_csr(aes_pkg::CSR_KEY_LOW, keys[p][63:0]);
         for (int ph = 0; ph < 4; ph++) begin
            phase = ph;
            pick_idle();
            for (int n = 0; n < 73; n++)
               send_item(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
            if (ph == 1) wait_drain();
         end
         phase = 0;
         pick_idle();
         wait_drain();
      end
      if (mismatches == 0) $display("[aes128_block_cipher_unit] OK");
      else $display("[aes128_block_cipher_unit] ERROR");
      $finish;
   end
endmodule
